### hdl/hipcd_pkg.sv
// Package with shared types and constants for the indexed/HAM pixel color decoder.
`default_nettype none

package hipcd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int COLOR_W       = 8;
  localparam int RGB_W         = 3 * COLOR_W;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 8;

  localparam logic [3:0]         DEPTH_RESET = 4'd6;
  localparam logic [3:0]         DEPTH_MAX   = 4'd8;
  localparam logic [3:0]         DEPTH_HAM   = 4'd5;
  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'h00;

  localparam logic OP_PALETTE_WRITE = 1'b0;
  localparam logic OP_PIXEL         = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_DEPTH        = 8'd0,
    REG_HAM_ENABLE         = 8'd1,
    REG_TRANSPARENT_ENABLE = 8'd2,
    REG_TRANSPARENT_INDEX  = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HAM_LOAD  = 2'd0,
    HAM_RED   = 2'd1,
    HAM_BLUE  = 2'd2,
    HAM_GREEN = 2'd3
  } ham_ctrl_e;

  typedef struct packed {
    logic               frame_start;
    logic               ham_on;
    ham_ctrl_e          ham_ctrl;
    logic [COLOR_W-1:0] mod;
    logic               idx_ok;
    logic               transparent;
  } s1_ctrl_t;

endpackage

`default_nettype wire

### hdl/hipcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hipcd_ram #(
  parameter int Width = 24,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/ham_indexed_pixel_color_decoder_unit.sv
// A pixel accepted at the input is registered in stage 1 and then in the output register;
// while the output is stalled it is held in stage 1.
// Throughput: one item per cycle while the output is not stalled; the palette RAM read port feeds one pixel per cycle.
// Palette writes produce no output transfer.
// Reset clears config to defaults (depth 6), held color to zero and all valids.
// Palette contents are undefined after reset until written.
`default_nettype none

module ham_indexed_pixel_color_decoder_unit #(
  parameter int TableEntries = hipcd_pkg::TABLE_ENTRIES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [hipcd_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [hipcd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                in_op_i,
  input  wire logic                                in_frame_start_i,
  input  wire logic [7:0]                          in_code_i,
  input  wire logic [hipcd_pkg::COLOR_W-1:0]       in_entry_red_i,
  input  wire logic [hipcd_pkg::COLOR_W-1:0]       in_entry_green_i,
  input  wire logic [hipcd_pkg::COLOR_W-1:0]       in_entry_blue_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [hipcd_pkg::COLOR_W-1:0]            pixel_red_o,
  output logic [hipcd_pkg::COLOR_W-1:0]            pixel_green_o,
  output logic [hipcd_pkg::COLOR_W-1:0]            pixel_blue_o,
  output logic [hipcd_pkg::COLOR_W-1:0]            pixel_alpha_o
);

  localparam int AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [8:0] TableLimit = 9'(TableEntries);

  // Configuration registers
  logic [3:0] color_depth_q, color_depth_d;
  logic       ham_enable_q, ham_enable_d;
  logic       trans_en_q, trans_en_d;
  logic [7:0] trans_idx_q, trans_idx_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    color_depth_d = color_depth_q;
    ham_enable_d  = ham_enable_q;
    trans_en_d    = trans_en_q;
    trans_idx_d   = trans_idx_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hipcd_pkg::REG_COLOR_DEPTH:        color_depth_d = cfg_data_i[3:0];
        hipcd_pkg::REG_HAM_ENABLE:         ham_enable_d  = cfg_data_i[0];
        hipcd_pkg::REG_TRANSPARENT_ENABLE: trans_en_d    = cfg_data_i[0];
        hipcd_pkg::REG_TRANSPARENT_INDEX:  trans_idx_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_depth_q <= hipcd_pkg::DEPTH_RESET;
      ham_enable_q  <= 1'b0;
      trans_en_q    <= 1'b0;
      trans_idx_q   <= 8'd0;
    end else begin
      color_depth_q <= color_depth_d;
      ham_enable_q  <= ham_enable_d;
      trans_en_q    <= trans_en_d;
      trans_idx_q   <= trans_idx_d;
    end
  end

  // Pipeline handshake
  logic                s1_valid_q, s1_valid_d;
  hipcd_pkg::s1_ctrl_t s1_ctrl_q, s1_ctrl_d;
  logic                s1_advance;
  logic                in_accept;
  logic                pix_accept;
  logic                wr_accept;

  assign s1_advance = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pix_accept = in_accept && (in_op_i == hipcd_pkg::OP_PIXEL);
  assign wr_accept  = in_accept && (in_op_i == hipcd_pkg::OP_PALETTE_WRITE);
  assign s1_valid_d = pix_accept || (s1_valid_q && !s1_advance);

  // Stage 0: field split and palette address
  logic [3:0] depth_eff;
  logic       ham_on;
  logic [1:0] ctrl_bits;
  logic [7:0] ham_data;
  logic [7:0] ham_mod;
  logic [7:0] rd_idx;

  always_comb begin
    depth_eff = (color_depth_q > hipcd_pkg::DEPTH_MAX) ? hipcd_pkg::DEPTH_MAX : color_depth_q;
    ham_on    = ham_enable_q && (depth_eff >= hipcd_pkg::DEPTH_HAM);
    case (depth_eff)
      4'd5: begin
        ctrl_bits = in_code_i[4:3];
        ham_data  = {5'd0, in_code_i[2:0]};
        ham_mod   = {in_code_i[2:0], 5'd0};
      end
      4'd6: begin
        ctrl_bits = in_code_i[5:4];
        ham_data  = {4'd0, in_code_i[3:0]};
        ham_mod   = {in_code_i[3:0], 4'd0};
      end
      4'd7: begin
        ctrl_bits = in_code_i[6:5];
        ham_data  = {3'd0, in_code_i[4:0]};
        ham_mod   = {in_code_i[4:0], 3'd0};
      end
      default: begin
        ctrl_bits = in_code_i[7:6];
        ham_data  = {2'd0, in_code_i[5:0]};
        ham_mod   = {in_code_i[5:0], 2'd0};
      end
    endcase
    rd_idx = ham_on ? ham_data : in_code_i;

    s1_ctrl_d             = s1_ctrl_q;
    if (pix_accept) begin
      s1_ctrl_d.frame_start = in_frame_start_i;
      s1_ctrl_d.ham_on      = ham_on;
      s1_ctrl_d.ham_ctrl    = hipcd_pkg::ham_ctrl_e'(ctrl_bits);
      s1_ctrl_d.mod         = ham_mod;
      s1_ctrl_d.idx_ok      = {1'b0, rd_idx} < TableLimit;
      s1_ctrl_d.transparent = trans_en_q && (in_code_i == trans_idx_q);
    end
  end

  logic                          wr_ok;
  logic [hipcd_pkg::RGB_W-1:0]   rdata;

  assign wr_ok = {1'b0, in_code_i} < TableLimit;

  hipcd_ram #(
    .Width (hipcd_pkg::RGB_W),
    .Depth (TableEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_accept && wr_ok),
    .waddr_i (in_code_i[AddrW-1:0]),
    .wdata_i ({in_entry_red_i, in_entry_green_i, in_entry_blue_i}),
    .re_i    (pix_accept),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctrl_q <= s1_ctrl_d;
  end

  // Stage 1: held color update and result
  logic [hipcd_pkg::RGB_W-1:0]   held_q, held_d;
  logic [hipcd_pkg::RGB_W-1:0]   held_base;
  logic [hipcd_pkg::RGB_W-1:0]   held_new;
  logic [hipcd_pkg::RGB_W-1:0]   entry;
  logic [hipcd_pkg::RGB_W-1:0]   res_rgb;
  logic [hipcd_pkg::COLOR_W-1:0] res_alpha;

  always_comb begin
    held_base = s1_ctrl_q.frame_start ? '0 : held_q;
    entry     = s1_ctrl_q.idx_ok ? rdata : '0;
    held_new  = held_base;
    if (s1_ctrl_q.ham_on) begin
      unique case (s1_ctrl_q.ham_ctrl)
        hipcd_pkg::HAM_LOAD:  held_new        = entry;
        hipcd_pkg::HAM_RED:   held_new[23:16] = s1_ctrl_q.mod;
        hipcd_pkg::HAM_GREEN: held_new[15:8]  = s1_ctrl_q.mod;
        hipcd_pkg::HAM_BLUE:  held_new[7:0]   = s1_ctrl_q.mod;
        default: ;
      endcase
      res_rgb   = held_new;
      res_alpha = hipcd_pkg::ALPHA_OPAQUE;
    end else begin
      res_rgb   = entry;
      res_alpha = s1_ctrl_q.transparent ? hipcd_pkg::ALPHA_CLEAR : hipcd_pkg::ALPHA_OPAQUE;
    end
    held_d = s1_advance ? held_new : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [hipcd_pkg::RGB_W-1:0]   out_rgb_q, out_rgb_d;
  logic [hipcd_pkg::COLOR_W-1:0] out_alpha_q, out_alpha_d;

  assign out_valid_d = s1_advance || (out_valid_q && out_stall_i);
  assign out_rgb_d   = s1_advance ? res_rgb : out_rgb_q;
  assign out_alpha_d = s1_advance ? res_alpha : out_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rgb_q   <= out_rgb_d;
    out_alpha_q <= out_alpha_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = out_rgb_q[23:16];
  assign pixel_green_o = out_rgb_q[15:8];
  assign pixel_blue_o  = out_rgb_q[7:0];
  assign pixel_alpha_o = out_alpha_q;

  // Checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_accept |=> !s1_valid_q)
    else $error("palette write entered the result pipeline");

  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_o)
    else $error("stage 1 result lost");

endmodule

`default_nettype wire
